[rtl/rlfwt_pkg.sv]
// Package for the run-length FIFO with weighted take.
// Holds the item and result beat types, command and status codes.
// No dependencies; used by run_length_fifo_weighted_take.
package rlfwt_pkg;

	// Width of a run count and of a run value.
	localparam int FIELD_BITS = 30;
	// Width of the accumulated sum of taken values.
	localparam int SUM_BITS = 60;

	// Command codes.
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_TAKE = 1'b1;

	// Status codes.
	typedef logic [1:0] status_t;
	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_FULL  = 2'd1;
	localparam status_t STATUS_SHORT = 2'd2;

	// One input beat.
	typedef struct packed {
		logic                  cmd;
		logic [FIELD_BITS-1:0] item_value;
		logic [FIELD_BITS-1:0] unit_count;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic [SUM_BITS-1:0] taken_sum;
		status_t             status;
	} result_t;

endpackage

[rtl/run_length_fifo_weighted_take.sv]
// Run-length FIFO with weighted take: top level.
// Ring of runs in one memory, a shared multiplier and a small sequencer.
// Depends on rlfwt_pkg.
//
//   channel   handshake           payload    direction
//   item      start / busy        item_t     in
//   result    done (strobe only)  result_t   out
//
// A push leaves busy low and its result beat appears on the following cycle.
// A take reads the head run, then for each run it touches compares and updates,
// multiplies and accumulates; busy is high until the last run is accumulated,
// and the result beat appears in the cycle after that.
// Reset clears head, tail, occupancy and the sequencer; the run memory is
// not cleared, since only runs between head and tail are ever read.
// The receiver cannot stall: done is high for exactly one cycle per item.
module run_length_fifo_weighted_take #(
	parameter int RUN_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rlfwt_pkg::item_t   item,
	output logic              done,
	output rlfwt_pkg::result_t result
);
	import rlfwt_pkg::*;

	localparam int IDX_W = $clog2(RUN_DEPTH);
	localparam int OCC_W = $clog2(RUN_DEPTH + 1);
	localparam int ENT_W = 2 * FIELD_BITS;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_MUL  = 4'b0100,
		S_ACC  = 4'b1000
	} state_t;

	state_t                state_q;
	logic [IDX_W-1:0]      head_q;
	logic [IDX_W-1:0]      tail_q;
	logic [OCC_W-1:0]      occ_q;
	logic [FIELD_BITS-1:0] left_q;
	logic [FIELD_BITS-1:0] part_q;
	logic [FIELD_BITS-1:0] val_q;
	logic [ENT_W-1:0]      prod_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [ENT_W-1:0]      rdata_q;
	logic                  done_q;
	result_t               result_q;

	// Run memory: each entry is {value, count}.
	logic [ENT_W-1:0] run_mem [RUN_DEPTH];

	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [ENT_W-1:0]      wr_data;
	logic                  rd_en;
	logic                  accept;
	logic                  ring_full;
	logic                  take_more;
	logic [FIELD_BITS-1:0] have;
	logic [FIELD_BITS-1:0] part;
	logic [IDX_W-1:0]      head_next;
	logic [IDX_W-1:0]      tail_next;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign ring_full = (occ_q == OCC_W'(RUN_DEPTH));
	assign done      = done_q;
	assign result    = result_q;

	// Ring index stepping with wrap at the depth.
	assign head_next = (head_q == IDX_W'(RUN_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == IDX_W'(RUN_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// Units to take from the head run: the smaller of what it holds and what is left.
	assign have = rdata_q[FIELD_BITS-1:0];
	assign part = (have < left_q) ? have : left_q;

	// The take goes on while units are wanted and runs remain.
	assign take_more = (left_q != '0) && (occ_q != '0);

	// Memory port control: push writes at the tail, a partial take writes back.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tail_q;
		wr_data = {item.item_value, item.unit_count};
		rd_en   = 1'b0;
		case (state_q)
			S_IDLE: begin
				wr_en = accept && (item.cmd == CMD_PUSH) && !ring_full;
			end
			S_CMP: begin
				wr_en   = (part != have);
				wr_addr = head_q;
				wr_data = {rdata_q[ENT_W-1:FIELD_BITS], have - part};
			end
			S_ACC: begin
				rd_en = take_more;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Run memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			run_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= run_mem[head_q];
		end
	end

	// Datapath registers: shared multiplier and accumulator.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				left_q <= item.unit_count;
				sum_q  <= '0;
				prod_q <= '0;
			end
			S_CMP: begin
				part_q <= part;
				val_q  <= rdata_q[ENT_W-1:FIELD_BITS];
				left_q <= left_q - part;
			end
			S_MUL: begin
				prod_q <= ENT_W'(part_q) * ENT_W'(val_q);
			end
			S_ACC: begin
				sum_q <= sum_q + SUM_BITS'(prod_q);
			end
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

	// Sequencer and ring pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.cmd == CMD_PUSH) begin
							done_q <= 1'b1;
							if (!ring_full) begin
								tail_q <= tail_next;
								occ_q  <= occ_q + 1'b1;
							end
						end else begin
							state_q <= S_ACC;
						end
					end
				end
				S_CMP: begin
					if (part == have) begin
						head_q <= head_next;
						occ_q  <= occ_q - 1'b1;
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (take_more) begin
						state_q <= S_CMP;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result beat register.
	always_ff @(posedge clk) begin
		if (accept && (item.cmd == CMD_PUSH)) begin
			result_q.taken_sum <= '0;
			result_q.status    <= ring_full ? STATUS_FULL : STATUS_OK;
		end else if ((state_q == S_ACC) && !take_more) begin
			result_q.taken_sum <= sum_q + SUM_BITS'(prod_q);
			result_q.status    <= (left_q != '0) ? STATUS_SHORT : STATUS_OK;
		end
	end

	// Occupancy never exceeds the ring depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(RUN_DEPTH))
		else $error("run occupancy above ring depth");

	// An empty ring has head and tail at the same slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> (head_q == tail_q))
		else $error("empty ring with head and tail apart");

	// A run is only examined while the ring holds one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (occ_q != '0))
		else $error("head run examined on empty ring");

	// The multiply step always hands over to the accumulate step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |=> (state_q == S_ACC))
		else $error("multiply not followed by accumulate");

	// A dropped push reports a zero sum.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == STATUS_FULL)) |-> (result.taken_sum == '0))
		else $error("dropped push with nonzero sum");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for run_length_fifo_weighted_take.
// Pushes and takes beats through start/busy, predicts each result beat from its own run ring
// and checks every done strobe against it. Depends on rlfwt_pkg and the RTL top level.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rlfwt_pkg::*;

	localparam int RUN_DEPTH = 1024;
	localparam longint unsigned FIELD_MAX = (64'd1 << FIELD_BITS) - 1;

	// A queued input beat; a drain beat waits until every expected result has come.
	typedef struct {
		item_t beat;
		bit    drain;
	} pending_t;

	logic    clk = 1'b1;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy;
	logic    done;
	result_t result;

	pending_t pending[$];
	result_t  sums_due[$];
	int       mismatch_count = 0;
	int       beats_sent = 0;
	int       idle_left = 0;

	// Predicted ring of runs.
	logic [FIELD_BITS-1:0] run_len[RUN_DEPTH];
	logic [FIELD_BITS-1:0] run_val[RUN_DEPTH];
	int                    head_slot = 0;
	int                    tail_slot = 0;
	int                    runs_held = 0;

	run_length_fifo_weighted_take #(
		.RUN_DEPTH(RUN_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	// Clock: 4 ns period.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Print one line per mismatch and count it.
	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// Work out the result of one accepted beat and advance the predicted ring.
	task automatic apply_to_runs(input item_t beat);
		result_t               outcome;
		logic [FIELD_BITS-1:0] left;
		logic [FIELD_BITS-1:0] part;
		outcome = '0;
		outcome.status = STATUS_OK;
		if (beat.cmd == CMD_PUSH) begin
			if (runs_held >= RUN_DEPTH) begin
				outcome.status = STATUS_FULL;
			end else begin
				run_len[tail_slot] = beat.unit_count;
				run_val[tail_slot] = beat.item_value;
				tail_slot = (tail_slot == RUN_DEPTH - 1) ? 0 : tail_slot + 1;
				runs_held++;
			end
		end else begin
			left = beat.unit_count;
			while (left != 0 && runs_held != 0) begin
				part = (run_len[head_slot] < left) ? run_len[head_slot] : left;
				outcome.taken_sum += SUM_BITS'(part) * SUM_BITS'(run_val[head_slot]);
				left -= part;
				if (part == run_len[head_slot]) begin
					head_slot = (head_slot == RUN_DEPTH - 1) ? 0 : head_slot + 1;
					runs_held--;
				end else begin
					run_len[head_slot] -= part;
				end
			end
			if (left != 0) begin
				outcome.status = STATUS_SHORT;
			end
		end
		sums_due = {sums_due, outcome};
	endtask

	// Idle cycles after a beat: mostly none or short, a few long, and stretches of back-to-back beats.
	function automatic int pick_gap();
		int roll;
		if ((beats_sent / 150) % 4 == 3) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 93) begin
			return $urandom_range(1, 3);
		end else begin
			return $urandom_range(10, 40);
		end
	endfunction

	// A field value biased toward the edges and small numbers.
	function automatic logic [FIELD_BITS-1:0] pick_field();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return FIELD_BITS'(FIELD_MAX);
			end
			2, 3, 4: begin
				return FIELD_BITS'($urandom_range(0, 15));
			end
			default: begin
				return FIELD_BITS'($urandom);
			end
		endcase
	endfunction

	task automatic queue_beat(input logic cmd, input longint unsigned value,
		input longint unsigned count, input bit drain);
		pending_t entry;
		entry.beat.cmd = cmd;
		entry.beat.item_value = FIELD_BITS'(value);
		entry.beat.unit_count = FIELD_BITS'(count);
		entry.drain = drain;
		pending = {pending, entry};
	endtask

	// One random beat of the mixed phase: pushes of mostly short runs, takes of a few units.
	task automatic queue_mixed();
		if ($urandom_range(0, 99) < 55) begin
			queue_beat(CMD_PUSH, pick_field(),
				($urandom_range(0, 9) == 0) ? pick_field() : $urandom_range(0, 20), 1'b0);
		end else begin
			queue_beat(CMD_TAKE, $urandom,
				($urandom_range(0, 19) == 0) ? pick_field() : $urandom_range(0, 40), 1'b0);
		end
	endtask

	// Driver: retire the accepted beat into the predictor, then present the next one.
	always @(posedge clk or negedge arst_n) begin : drive_beats
		logic     launch;
		pending_t entry;
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			idle_left = 0;
		end else begin
			launch = start;
			if (start && !busy) begin
				apply_to_runs(item);
				beats_sent++;
				launch = 1'b0;
				idle_left = pick_gap();
			end
			if (!launch) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (pending.size() != 0 &&
					(!pending[0].drain || sums_due.size() == 0)) begin
					entry = pending[0];
					pending.delete(0);
					item <= entry.beat;
					launch = 1'b1;
				end
			end
			start <= launch;
		end
	end

	// Monitor: every done strobe carries one result beat, checked against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (sums_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result beat sum=%0h status=%0d",
					result.taken_sum, result.status));
			end else begin
				want = sums_due[0];
				sums_due.delete(0);
				if (result.taken_sum !== want.taken_sum) begin
					flag_mismatch($sformatf("taken_sum %0h, expected %0h",
						result.taken_sum, want.taken_sum));
				end
				if (result.status !== want.status) begin
					flag_mismatch($sformatf("status %0d, expected %0d",
						result.status, want.status));
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		// Directed: empty takes, extreme runs, zero-length runs and takes, shortfalls.
		queue_beat(CMD_TAKE, 0, 0, 1'b0);
		queue_beat(CMD_TAKE, FIELD_MAX, 5, 1'b0);
		queue_beat(CMD_PUSH, FIELD_MAX, FIELD_MAX, 1'b0);
		queue_beat(CMD_PUSH, 0, 0, 1'b0);
		queue_beat(CMD_PUSH, 1, 3, 1'b0);
		queue_beat(CMD_TAKE, 0, FIELD_MAX, 1'b0);
		queue_beat(CMD_TAKE, 0, 2, 1'b0);
		queue_beat(CMD_TAKE, 0, 4, 1'b0);
		queue_beat(CMD_PUSH, 0, 0, 1'b1);
		queue_beat(CMD_TAKE, FIELD_MAX, 0, 1'b0);
		queue_beat(CMD_TAKE, 0, 1, 1'b0);
		queue_beat(CMD_PUSH, 30'h2AAAAAAA, 30'h15555555, 1'b0);
		queue_beat(CMD_PUSH, 30'h15555555, 30'h2AAAAAAA, 1'b0);
		queue_beat(CMD_PUSH, FIELD_MAX, 1, 1'b0);
		queue_beat(CMD_TAKE, 30'h15555555, 30'h15555556, 1'b0);
		queue_beat(CMD_TAKE, 0, FIELD_MAX, 1'b0);
		queue_beat(CMD_TAKE, 0, FIELD_MAX, 1'b0);

		// Random mix of pushes and takes.
		repeat (450) queue_mixed();

		// Fill the ring past full so the last pushes are dropped.
		repeat (1030) begin
			queue_beat(CMD_PUSH, pick_field(), $urandom_range(0, 3), 1'b0);
		end
		queue_beat(CMD_TAKE, 0, $urandom_range(1, 50), 1'b1);
		queue_beat(CMD_PUSH, pick_field(), pick_field(), 1'b0);
		queue_beat(CMD_PUSH, pick_field(), pick_field(), 1'b0);
		queue_beat(CMD_TAKE, 0, $urandom_range(100, 2000), 1'b0);

		// More random mix, then empty the ring.
		repeat (150) queue_mixed();
		repeat (3) queue_beat(CMD_TAKE, $urandom, FIELD_MAX, 1'b0);

		// Hold reset, then release it on a falling edge, away from the rising clock edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || start) @(negedge clk);
		while (sums_due.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
